/* rtl/core/paba_pkg.sv */
// Shared types and codes for the paged block pool allocator.
package paba_pkg;

	localparam int IDX_W  = 8;
	localparam int CNT_W  = 4;
	localparam int STAT_W = 2;

	localparam logic OP_ALLOC  = 1'b0;
	localparam logic OP_RETURN = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_BAD_RETURN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		K_POP,
		K_FRESH,
		K_RETURN,
		K_EXHAUST,
		K_BAD
	} kind_t;

	typedef struct packed {
		logic inc;
		logic dec;
	} cnt_ctrl_t;

endpackage

/* rtl/core/paged_block_pool_allocator.sv */
// Paged block pool allocator: LIFO free list, fresh-index fill, per-page in-use counts.
// A request is registered in the input stage, then done rises from the result register.
// A request is taken only while busy is low; busy is high in the cycle after each transfer
// while the registered link and taken reads are consumed and the state is updated.
// Reset (arst_n low) empties the free list, clears page counts and the fresh index at once;
// the link and taken memories are not cleared. The result receiver cannot stall.
module paged_block_pool_allocator #(
	parameter int BLOCKS_PER_PAGE = 10,
	parameter int MAX_PAGES       = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        operation,
	input  logic [paba_pkg::IDX_W-1:0]  return_index,
	output logic                        done,
	output logic [paba_pkg::IDX_W-1:0]  block_index,
	output logic [paba_pkg::CNT_W-1:0]  page_in_use,
	output logic [paba_pkg::STAT_W-1:0] status
);

	localparam int TOTAL = BLOCKS_PER_PAGE * MAX_PAGES;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int FW    = $clog2(TOTAL + 1);
	localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	// architectural state
	logic [AW-1:0]    stack_head_q;
	logic             stack_nonempty_q;
	logic [FW-1:0]    stack_depth_q;
	logic [FW-1:0]    fresh_next_q;
	logic             taken_mem [TOTAL];

	// input stage
	logic              valid_s1;
	paba_pkg::kind_t   kind_s1;
	logic [AW-1:0]     idx_s1;
	logic [PW-1:0]     page_s1;
	logic [paba_pkg::IDX_W-1:0] ridx_s1;
	logic              taken_s1;

	// result register
	logic                        done_q;
	logic [paba_pkg::IDX_W-1:0]  block_index_q;
	logic [paba_pkg::CNT_W-1:0]  page_in_use_q;
	logic [paba_pkg::STAT_W-1:0] status_q;

	logic              accept;
	paba_pkg::kind_t   kind_s0;
	paba_pkg::kind_t   kind_eff;
	logic [AW-1:0]     idx_s0;
	logic [PW-1:0]     page_s0;
	logic              ret_in_range;
	logic              taken_we;
	logic              taken_wdata;
	logic [AW-1:0]     link_rd;
	logic              mem_we;
	paba_pkg::cnt_ctrl_t cnt_ctrl;
	logic [paba_pkg::CNT_W-1:0] cnt_next;

	assign busy   = valid_s1;
	assign accept = start && !busy;

	// classify the request against the current state; the taken check follows in stage 1
	assign ret_in_range = (16'(return_index) < 16'(fresh_next_q));

	always_comb begin
		kind_s0 = paba_pkg::K_EXHAUST;
		idx_s0  = '0;
		if (operation == paba_pkg::OP_ALLOC) begin
			if (stack_nonempty_q) begin
				kind_s0 = paba_pkg::K_POP;
				idx_s0  = stack_head_q;
			end else if (fresh_next_q < FW'(TOTAL)) begin
				kind_s0 = paba_pkg::K_FRESH;
				idx_s0  = AW'(fresh_next_q);
			end
		end else if (ret_in_range) begin
			kind_s0 = paba_pkg::K_RETURN;
			idx_s0  = AW'(return_index);
		end else begin
			kind_s0 = paba_pkg::K_BAD;
		end
	end

	paba_page_div #(
		.BLOCKS_PER_PAGE(BLOCKS_PER_PAGE),
		.AW             (AW),
		.PW             (PW)
	) u_page_div (
		.idx (idx_s0),
		.page(page_s0)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_s0;
			idx_s1  <= idx_s0;
			page_s1 <= page_s0;
			ridx_s1 <= return_index;
		end
	end

	// a taken flag is read only below the fresh index, where it has always been written
	always_ff @(posedge clk) begin
		if (accept && (kind_s0 == paba_pkg::K_RETURN)) begin
			taken_s1 <= taken_mem[idx_s0];
		end
	end

	// drop a return of a block that is not out
	always_comb begin
		kind_eff = kind_s1;
		if ((kind_s1 == paba_pkg::K_RETURN) && !taken_s1) begin
			kind_eff = paba_pkg::K_BAD;
		end
	end

	assign taken_we = valid_s1 &&
		(kind_eff inside {paba_pkg::K_POP, paba_pkg::K_FRESH, paba_pkg::K_RETURN});
	assign taken_wdata = (kind_eff != paba_pkg::K_RETURN);

	always_ff @(posedge clk) begin
		if (taken_we) begin
			taken_mem[idx_s1] <= taken_wdata;
		end
	end

	// fetch the link below the head while the request sits in the input stage
	assign mem_we = valid_s1 && (kind_eff == paba_pkg::K_RETURN);

	paba_link_mem #(
		.DEPTH(TOTAL),
		.AW   (AW)
	) u_link_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(idx_s1),
		.wdata(stack_head_q),
		.re   (accept),
		.raddr(stack_head_q),
		.rdata(link_rd)
	);

	assign cnt_ctrl.inc = valid_s1 &&
		((kind_eff == paba_pkg::K_POP) || (kind_eff == paba_pkg::K_FRESH));
	assign cnt_ctrl.dec = mem_we;

	paba_page_cnt #(
		.MAX_PAGES(MAX_PAGES),
		.PW       (PW)
	) u_page_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (cnt_ctrl),
		.page    (page_s1),
		.cnt_next(cnt_next)
	);

	// update stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_head_q     <= '0;
			stack_nonempty_q <= 1'b0;
			stack_depth_q    <= '0;
			fresh_next_q     <= '0;
		end else if (valid_s1) begin
			case (kind_eff)
				paba_pkg::K_POP: begin
					stack_head_q     <= link_rd;
					stack_depth_q    <= stack_depth_q - FW'(1);
					stack_nonempty_q <= (stack_depth_q != FW'(1));
				end
				paba_pkg::K_FRESH: begin
					fresh_next_q <= fresh_next_q + FW'(1);
				end
				paba_pkg::K_RETURN: begin
					stack_head_q     <= idx_s1;
					stack_depth_q    <= stack_depth_q + FW'(1);
					stack_nonempty_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			case (kind_eff)
				paba_pkg::K_POP, paba_pkg::K_FRESH, paba_pkg::K_RETURN: begin
					block_index_q <= paba_pkg::IDX_W'(idx_s1);
					page_in_use_q <= cnt_next;
					status_q      <= paba_pkg::ST_OK;
				end
				paba_pkg::K_BAD: begin
					block_index_q <= ridx_s1;
					page_in_use_q <= '0;
					status_q      <= paba_pkg::ST_BAD_RETURN;
				end
				default: begin
					block_index_q <= '0;
					page_in_use_q <= '0;
					status_q      <= paba_pkg::ST_EXHAUSTED;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign block_index = block_index_q;
	assign page_in_use = page_in_use_q;
	assign status      = status_q;

	// every transfer yields a result after the input stage and the result register
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing after transfer");

	a_single_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_depth_flag: assert property (@(posedge clk) disable iff (!arst_n)
		stack_nonempty_q == (stack_depth_q != '0))
		else $error("free list flag disagrees with depth");

	a_exhaust_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == paba_pkg::ST_EXHAUSTED)) |-> ((block_index == '0) &&
		(page_in_use == '0) && (fresh_next_q == FW'(TOTAL)) && !stack_nonempty_q))
		else $error("exhausted result with free blocks left");

endmodule

/* rtl/core/paba_link_mem.sv */
// Free-list link memory: one write port, one registered read port.
module paba_link_mem #(
	parameter int DEPTH = 160,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/paba_page_div.sv */
// Block index to page number by reciprocal multiplication.
module paba_page_div #(
	parameter int BLOCKS_PER_PAGE = 10,
	parameter int AW              = 8,
	parameter int PW              = 4
) (
	input  logic [AW-1:0] idx,
	output logic [PW-1:0] page
);

	localparam int SHIFT = 16;
	localparam int RECIP = ((1 << SHIFT) + BLOCKS_PER_PAGE - 1) / BLOCKS_PER_PAGE;
	localparam int PROD_W = AW + SHIFT + 1;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;

	// exact for every index below 2**AW since the reciprocal error stays under one step
	assign prod = PROD_W'(idx) * PROD_W'(RECIP);
	assign quot = prod >> SHIFT;
	assign page = quot[PW-1:0];

endmodule

/* rtl/core/paba_page_cnt.sv */
// In-use counters, one per page, with increment and saturating decrement.
module paba_page_cnt #(
	parameter int MAX_PAGES = 16,
	parameter int PW        = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  paba_pkg::cnt_ctrl_t     ctrl,
	input  logic [PW-1:0]           page,
	output logic [paba_pkg::CNT_W-1:0] cnt_next
);

	logic [paba_pkg::CNT_W-1:0] cnt_q [MAX_PAGES];
	logic [paba_pkg::CNT_W-1:0] cnt_cur;

	assign cnt_cur = cnt_q[page];

	always_comb begin
		cnt_next = cnt_cur;
		if (ctrl.inc) begin
			cnt_next = cnt_cur + paba_pkg::CNT_W'(1);
		end else if (ctrl.dec && (cnt_cur != '0)) begin
			cnt_next = cnt_cur - paba_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (ctrl.inc || ctrl.dec) begin
			cnt_q[page] <= cnt_next;
		end
	end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the paged block pool allocator.
`timescale 1ns / 100ps

localparam int BPP    = 10;
localparam int PAGES  = 16;
localparam int BLOCKS = BPP * PAGES;

typedef struct packed {
	logic [paba_pkg::IDX_W-1:0] idx;
	logic [paba_pkg::CNT_W-1:0] cnt;
	paba_pkg::status_t          st;
} pool_reply_t;

// Shadow copy of the pool: computes the reply for every request and holds
// the replies that are still due from the block.
class pool_tracker;
	logic [paba_pkg::IDX_W-1:0] link [BLOCKS];
	logic [paba_pkg::IDX_W-1:0] head;
	bit               nonempty;
	int               depth;
	int               fresh;
	int               counts [PAGES];
	bit               taken [BLOCKS];
	int               held;
	int               mismatches;
	pool_reply_t      due_replies [$];

	task flag_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function void book_request(logic op, logic [paba_pkg::IDX_W-1:0] ridx);
		pool_reply_t r;
		int          idx;
		int          page;
		if (op == paba_pkg::OP_ALLOC) begin
			if (nonempty) begin
				idx = head;
				head = link[idx];
				if (depth > 0) depth--;
				nonempty = (depth != 0);
			end else if (fresh < BLOCKS) begin
				idx = fresh;
				fresh++;
			end else begin
				r.idx = '0;
				r.cnt = '0;
				r.st  = paba_pkg::ST_EXHAUSTED;
				due_replies.push_back(r);
				return;
			end
			taken[idx] = 1'b1;
			held++;
			page = idx / BPP;
			counts[page]++;
			r.idx = idx[paba_pkg::IDX_W-1:0];
			r.cnt = counts[page][paba_pkg::CNT_W-1:0];
			r.st  = paba_pkg::ST_OK;
		end else if (ridx >= BLOCKS || ridx >= fresh || !taken[ridx]) begin
			r.idx = ridx;
			r.cnt = '0;
			r.st  = paba_pkg::ST_BAD_RETURN;
		end else begin
			taken[ridx] = 1'b0;
			held--;
			page = ridx / BPP;
			if (counts[page] > 0) counts[page]--;
			link[ridx] = head;
			head = ridx;
			depth++;
			nonempty = 1'b1;
			r.idx = ridx;
			r.cnt = counts[page][paba_pkg::CNT_W-1:0];
			r.st  = paba_pkg::ST_OK;
		end
		due_replies.push_back(r);
	endfunction

	task check_result(logic [paba_pkg::IDX_W-1:0] idx, logic [paba_pkg::CNT_W-1:0] cnt,
			logic [paba_pkg::STAT_W-1:0] st);
		pool_reply_t want;
		if (due_replies.size() == 0) begin
			flag_mismatch($sformatf("reply with none due: index %0d count %0d status %0d",
				idx, cnt, st));
			return;
		end
		want = due_replies.pop_front();
		if (idx !== want.idx)
			flag_mismatch($sformatf("block_index %0d, want %0d", idx, want.idx));
		if (cnt !== want.cnt)
			flag_mismatch($sformatf("page_in_use %0d, want %0d (index %0d)",
				cnt, want.cnt, want.idx));
		if (st !== want.st)
			flag_mismatch($sformatf("status %0d, want %0d (index %0d)",
				st, want.st, want.idx));
	endtask
endclass

module testbench;

	localparam int RANDOM_ITEMS = 1430;
	localparam int QUIET_TAIL   = 200;
	localparam int CYCLE_LIMIT  = 400000;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic                          operation;
	logic [paba_pkg::IDX_W-1:0]    return_index;
	logic                          done;
	logic [paba_pkg::IDX_W-1:0]    block_index;
	logic [paba_pkg::CNT_W-1:0]    page_in_use;
	logic [paba_pkg::STAT_W-1:0]   status;

	pool_tracker tracker;
	int          cycles = 0;

	paged_block_pool_allocator #(
		.BLOCKS_PER_PAGE(BPP),
		.MAX_PAGES(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.return_index(return_index),
		.done(done),
		.block_index(block_index),
		.page_in_use(page_in_use),
		.status(status)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) tracker.check_result(block_index, page_in_use, status);
	end

	// Present one request and hold it until the transfer happens.
	task automatic issue(logic op, logic [paba_pkg::IDX_W-1:0] ridx);
		@(negedge clk);
		start <= 1'b1;
		operation <= op;
		return_index <= ridx;
		forever begin
			@(posedge clk);
			if (!busy) break;
			@(negedge clk);
		end
		tracker.book_request(op, ridx);
	endtask

	task automatic pause(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	initial begin
		int                         i;
		int                         pick;
		int                         alloc_pct;
		int                         floor_level;
		bit                         filling;
		logic                       op;
		logic [paba_pkg::IDX_W-1:0] ridx;

		arst_n = 1'b0;
		start = 1'b0;
		operation = paba_pkg::OP_ALLOC;
		return_index = '0;
		tracker = new;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bad returns on an empty pool, including out of range.
		issue(paba_pkg::OP_RETURN, 8'd0);
		issue(paba_pkg::OP_RETURN, 8'd255);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_ALLOC, 8'd77);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_RETURN, 8'd1);
		// Second return of the same block, then one never handed out.
		issue(paba_pkg::OP_RETURN, 8'd1);
		issue(paba_pkg::OP_RETURN, 8'd5);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_RETURN, 8'd0);
		issue(paba_pkg::OP_RETURN, 8'd2);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		issue(paba_pkg::OP_RETURN, 8'd160);
		issue(paba_pkg::OP_RETURN, 8'd159);
		issue(paba_pkg::OP_RETURN, 8'd170);
		issue(paba_pkg::OP_RETURN, 8'd3);
		issue(paba_pkg::OP_RETURN, 8'd3);
		issue(paba_pkg::OP_ALLOC, 8'd0);
		pause(3);

		// Alternate fill and drain stretches: fill until dry, drain to at most 20 held blocks.
		filling = 1'b1;
		floor_level = 0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (filling && tracker.held == BLOCKS && $urandom_range(7) == 0) begin
				filling = 1'b0;
				floor_level = $urandom_range(20);
			end else if (!filling && tracker.held <= floor_level) begin
				filling = 1'b1;
			end
			alloc_pct = filling ? 80 : 25;
			if ($urandom_range(99) < alloc_pct) begin
				op = paba_pkg::OP_ALLOC;
				ridx = paba_pkg::IDX_W'($urandom_range(255));
			end else begin
				op = paba_pkg::OP_RETURN;
				if (tracker.held > 0 && $urandom_range(99) < 85) begin
					pick = $urandom_range(BLOCKS - 1);
					while (!tracker.taken[pick]) pick = $urandom_range(BLOCKS - 1);
					ridx = pick[paba_pkg::IDX_W-1:0];
				end else begin
					ridx = paba_pkg::IDX_W'($urandom_range(255));
				end
			end
			if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
				pause($urandom_range(1, 6));
			issue(op, ridx);
		end

		@(negedge clk);
		start <= 1'b0;
		while (tracker.due_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
